>>> rtl/tao_pkg.sv
`default_nettype none

package tao_pkg;

  localparam int PIX_W = 32;
  localparam int CH_W = 8;
  localparam int W_W = 16;
  localparam int NUM_W = 24;
  localparam int CHANNELS = 3;
  localparam int QBITS = 8;

  localparam logic ACTION_GLYPH = 1'b0;
  localparam logic ACTION_FILL = 1'b1;

  localparam logic [PIX_W-1:0] KEY_BLACK = 32'h0000_00FF;
  localparam logic [CH_W-1:0] ALPHA_MAX = 8'hFF;
  localparam logic [CH_W-1:0] ALPHA_ZERO = 8'h00;

  // Source, destination and weight that ride alongside the divider lanes.
  typedef struct packed {
    logic [PIX_W-1:0] src;
    logic [PIX_W-1:0] dest;
    logic [W_W-1:0]   w;
  } carry_t;

  // Exact floor(x / 255) for any product of two bytes.
  function automatic logic [CH_W-1:0] div255(input logic [W_W-1:0] x);
    logic [W_W:0] acc;
    acc = {1'b0, x} + (W_W+1)'(1) + (W_W+1)'(x >> 8);
    return acc[W_W-1:CH_W];
  endfunction

endpackage

`default_nettype wire

>>> rtl/tinted_alpha_over_blend_top.sv
`default_nettype none

// Tinted straight-alpha "over" compositor, one RGBA8888 pixel per transaction.
//
// Input channel: a transaction is taken at a rising edge where start is high and
// busy is low. busy is high only while rst is high, so outside reset one pixel can
// be taken on every clock cycle, with no gaps.
// Output channel: done is high for exactly one cycle with out_pixel and changed,
// once for each taken transaction, after it has passed every stage. The path is a
// fixed pipeline of thirteen register stages: input capture, glyph preparation,
// weight and product forming, numerator forming, eight stages of a restoring
// divider that retire one quotient bit each, and the output register. Results
// leave in the order their inputs arrived.
// The receiver cannot stall the output, and nothing here ever waits on it.
// Configuration: tint_enable is written through cfg_valid/cfg_ready/cfg_data and
// must only be changed while no pixel is in flight.
// Reset: rst is synchronous and active high. It empties the pipeline, drops
// done and clears tint_enable to zero; pixels in flight are discarded.
module tinted_alpha_over_blend_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         action,
  input  wire logic [tao_pkg::PIX_W-1:0]    src_pixel,
  input  wire logic [tao_pkg::PIX_W-1:0]    dest_pixel,
  input  wire logic [tao_pkg::PIX_W-1:0]    tint_color,
  output logic                              done,
  output logic [tao_pkg::PIX_W-1:0]         out_pixel,
  output logic                              changed,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic                         cfg_data
);

  localparam int LATENCY = 5 + tao_pkg::QBITS;

  logic tint_enable;
  logic accept;

  assign busy = rst;
  assign cfg_ready = !rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      tint_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      tint_enable <= cfg_data;
    end
  end

  // Stage A: capture the transaction.
  logic                      a_valid;
  logic                      a_action;
  logic [tao_pkg::PIX_W-1:0] a_src;
  logic [tao_pkg::PIX_W-1:0] a_dest;
  logic [tao_pkg::PIX_W-1:0] a_tint;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    a_action <= action;
    a_src <= src_pixel;
    a_dest <= dest_pixel;
    a_tint <= tint_color;
  end

  // Stage B: glyph preparation. For a glyph, opaque true black is keyed out first,
  // then the tint recolours it and scales its alpha, or only lends its alpha.
  logic                      b_valid;
  logic [tao_pkg::PIX_W-1:0] b_src;
  logic [tao_pkg::PIX_W-1:0] b_dest;
  logic [tao_pkg::PIX_W-1:0] b_src_next;

  always_comb begin
    logic [tao_pkg::PIX_W-1:0] keyed;
    logic [tao_pkg::CH_W-1:0]  ka;
    logic [tao_pkg::W_W-1:0]   prod;
    keyed = (a_src == tao_pkg::KEY_BLACK) ? '0 : a_src;
    ka = keyed[tao_pkg::CH_W-1:0];
    prod = tao_pkg::W_W'(a_tint[tao_pkg::CH_W-1:0]) * tao_pkg::W_W'(ka);
    if (a_action == tao_pkg::ACTION_FILL) begin
      b_src_next = a_src;
    end else if (tint_enable) begin
      if (ka == tao_pkg::ALPHA_MAX) begin
        b_src_next = a_tint;
      end else if (ka != tao_pkg::ALPHA_ZERO) begin
        b_src_next = {a_tint[tao_pkg::PIX_W-1:tao_pkg::CH_W], tao_pkg::div255(prod)};
      end else begin
        b_src_next = keyed;
      end
    end else if (ka != tao_pkg::ALPHA_ZERO) begin
      b_src_next = {keyed[tao_pkg::PIX_W-1:tao_pkg::CH_W], a_tint[tao_pkg::CH_W-1:0]};
    end else begin
      b_src_next = keyed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_src <= b_src_next;
    b_dest <= a_dest;
  end

  // Stage C: destination weight da*(255-sa), total weight W and the source
  // channel products cs*sa.
  logic                      c_valid;
  logic [tao_pkg::PIX_W-1:0] c_src;
  logic [tao_pkg::PIX_W-1:0] c_dest;
  logic [tao_pkg::W_W-1:0]   c_wd;
  logic [tao_pkg::W_W-1:0]   c_w;
  logic [tao_pkg::W_W-1:0]   c_ps [tao_pkg::CHANNELS];
  logic [tao_pkg::W_W-1:0]   c_wd_next;
  logic [tao_pkg::W_W-1:0]   c_w_next;
  logic [tao_pkg::W_W-1:0]   c_ps_next [tao_pkg::CHANNELS];

  always_comb begin
    logic [tao_pkg::CH_W-1:0] sa;
    logic [tao_pkg::CH_W-1:0] inv;
    logic [tao_pkg::W_W-1:0]  sa255;
    sa = b_src[tao_pkg::CH_W-1:0];
    inv = tao_pkg::ALPHA_MAX - sa;
    sa255 = (tao_pkg::W_W'(sa) << tao_pkg::CH_W) - tao_pkg::W_W'(sa);
    c_wd_next = tao_pkg::W_W'(b_dest[tao_pkg::CH_W-1:0]) * tao_pkg::W_W'(inv);
    c_w_next = sa255 + c_wd_next;
    for (int l = 0; l < tao_pkg::CHANNELS; l++) begin
      c_ps_next[l] = tao_pkg::W_W'(b_src[tao_pkg::PIX_W-1-tao_pkg::CH_W*l -: tao_pkg::CH_W])
                     * tao_pkg::W_W'(sa);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_src <= b_src;
    c_dest <= b_dest;
    c_wd <= c_wd_next;
    c_w <= c_w_next;
    c_ps <= c_ps_next;
  end

  // Stage D: numerators 255*cs*sa + cd*wd for the colour lanes. The alpha is
  // W divided by 255, formed from the carried weight at the output.
  logic                      d_valid;
  tao_pkg::carry_t           d_carry;
  logic [tao_pkg::NUM_W-1:0] d_num [tao_pkg::CHANNELS];
  logic [tao_pkg::NUM_W-1:0] d_num_next [tao_pkg::CHANNELS];

  always_comb begin
    logic [tao_pkg::NUM_W-1:0] ps;
    logic [tao_pkg::NUM_W-1:0] pd;
    for (int l = 0; l < tao_pkg::CHANNELS; l++) begin
      ps = tao_pkg::NUM_W'(c_ps[l]);
      pd = tao_pkg::NUM_W'(c_dest[tao_pkg::PIX_W-1-tao_pkg::CH_W*l -: tao_pkg::CH_W])
           * tao_pkg::NUM_W'(c_wd);
      d_num_next[l] = (ps << tao_pkg::CH_W) - ps + pd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_carry.src <= c_src;
    d_carry.dest <= c_dest;
    d_carry.w <= c_w;
    d_num <= d_num_next;
  end

  // Restoring divider, one quotient bit per stage, most significant bit first.
  // Every quotient fits in a byte, so eight stages suffice.
  logic                      div_valid [tao_pkg::QBITS];
  tao_pkg::carry_t           div_carry [tao_pkg::QBITS];
  logic [tao_pkg::NUM_W-1:0] div_rem   [tao_pkg::QBITS-1][tao_pkg::CHANNELS];
  logic [tao_pkg::QBITS-1:0] div_quo   [tao_pkg::QBITS][tao_pkg::CHANNELS];

  for (genvar k = 0; k < tao_pkg::QBITS; k++) begin : g_div
    localparam int SH = tao_pkg::QBITS - 1 - k;

    logic                      in_valid;
    tao_pkg::carry_t           in_carry;
    logic [tao_pkg::NUM_W-1:0] in_rem [tao_pkg::CHANNELS];
    logic [tao_pkg::QBITS-1:0] in_quo [tao_pkg::CHANNELS];
    logic [tao_pkg::NUM_W-1:0] rem_next [tao_pkg::CHANNELS];
    logic [tao_pkg::QBITS-1:0] quo_next [tao_pkg::CHANNELS];

    if (k == 0) begin : g_first
      always_comb begin
        in_valid = d_valid;
        in_carry = d_carry;
        for (int l = 0; l < tao_pkg::CHANNELS; l++) begin
          in_rem[l] = d_num[l];
          in_quo[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        in_valid = div_valid[k-1];
        in_carry = div_carry[k-1];
        for (int l = 0; l < tao_pkg::CHANNELS; l++) begin
          in_rem[l] = div_rem[k-1][l];
          in_quo[l] = div_quo[k-1][l];
        end
      end
    end

    always_comb begin
      logic [tao_pkg::NUM_W-1:0] trial;
      logic                      ge;
      trial = tao_pkg::NUM_W'(in_carry.w) << SH;
      for (int l = 0; l < tao_pkg::CHANNELS; l++) begin
        ge = (in_rem[l] >= trial);
        rem_next[l] = ge ? (in_rem[l] - trial) : in_rem[l];
        quo_next[l] = {in_quo[l][tao_pkg::QBITS-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_valid[k] <= 1'b0;
      end else begin
        div_valid[k] <= in_valid;
      end
    end

    always_ff @(posedge clk) begin
      div_carry[k] <= in_carry;
      div_quo[k] <= quo_next;
    end

    if (k < tao_pkg::QBITS - 1) begin : g_keep_rem
      always_ff @(posedge clk) begin
        div_rem[k] <= rem_next;
      end
    end
  end

  // Output register: a transparent source keeps the destination, an opaque one
  // copies the source, anything in between takes the divided channels.
  logic                      last_valid;
  tao_pkg::carry_t           last_carry;
  logic [tao_pkg::PIX_W-1:0] out_pixel_next;
  logic                      changed_next;

  assign last_valid = div_valid[tao_pkg::QBITS-1];
  assign last_carry = div_carry[tao_pkg::QBITS-1];

  always_comb begin
    logic [tao_pkg::CH_W-1:0] sa;
    sa = last_carry.src[tao_pkg::CH_W-1:0];
    if (sa == tao_pkg::ALPHA_ZERO) begin
      out_pixel_next = last_carry.dest;
      changed_next = 1'b0;
    end else if (sa == tao_pkg::ALPHA_MAX) begin
      out_pixel_next = last_carry.src;
      changed_next = 1'b1;
    end else begin
      out_pixel_next = {div_quo[tao_pkg::QBITS-1][0], div_quo[tao_pkg::QBITS-1][1],
                        div_quo[tao_pkg::QBITS-1][2], tao_pkg::div255(last_carry.w)};
      changed_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel <= out_pixel_next;
    changed <= changed_next;
  end

  // Every taken transaction produces exactly one result, a fixed time later.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(accept, LATENCY))
    else $error("result strobe does not match the input transaction stream");

  // An unchanged destination must come back exactly as it went in.
  a_keep_dest: assert property (@(posedge clk) disable iff (rst)
    (done && !changed) |-> (out_pixel == $past(dest_pixel, LATENCY)))
    else $error("unchanged result differs from the destination pixel");

  // A fill writes the destination exactly when its own alpha is nonzero.
  a_fill_changed: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(action, LATENCY) == tao_pkg::ACTION_FILL))
      |-> (changed == ($past(src_pixel[7:0], LATENCY) != tao_pkg::ALPHA_ZERO)))
    else $error("fill result changed flag disagrees with source alpha");

endmodule

`default_nettype wire
